[src/bcps_pkg.sv]
// ----------------------------------------------------------------------------
// bcps_pkg
// Shared constants and controller command type for the best candidate pair
// select unit.
// ----------------------------------------------------------------------------
package bcps_pkg;

   localparam int MAX_CANDIDATES = 64;
   localparam int MASS_BITS      = 24;
   localparam int CUT_BITS       = 10;
   localparam int MASK_BITS      = 64;
   localparam int COUNT_BITS     = 7;
   localparam int ANY_BITS       = 7;
   localparam int HIGH_BITS      = 6;
   localparam int FLOW_BITS      = ANY_BITS + HIGH_BITS;
   localparam int SLOT_IDX_BITS  = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;

   localparam logic [MASS_BITS-1:0] REF_MASS_RESET = MASS_BITS'(1459008);

   typedef struct packed {
      logic accept;     // candidate beat taken this cycle
      logic finish;     // accepted beat closes the event
      logic cfg_write;  // reference mass written
   } ctrl_cmd_type;

endpackage

[src/best_candidate_pair_select_unit.sv]
// ----------------------------------------------------------------------------
// best_candidate_pair_select_unit
// Streams one event's candidates and reports the best-matching pair set.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one candidate per beat; req_last_candidate closes the event.
//   rsp_*  : one result beat per event (best mask, cut-flow mask, count,
//            overflow flag).
//   csr_*  : write of the reference mass; only while no result is pending.
// Each candidate updates the running state, so a new candidate can be taken
// every cycle while req_stall is low. The result appears on rsp_valid the
// cycle after the last candidate is taken. A held result stalls the request
// side only while rsp_stall is high; otherwise the next event runs straight
// on and its result replaces the old one as it leaves.
// Candidates beyond 64 in an event are dropped and flagged in rsp_overflow.
// Reset (synchronous) clears the event state, drops any pending result and
// restores the reference mass to its default.
// ----------------------------------------------------------------------------
module best_candidate_pair_select_unit
   import bcps_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [MASS_BITS-1:0]        req_first_pair_mass,
   input  logic signed [MASS_BITS-1:0] req_second_pair_mass,
   input  logic [CUT_BITS-1:0]         req_cut_bits,
   input  logic                        req_mixed_flavour,
   input  logic                        req_last_candidate,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [MASK_BITS-1:0]        rsp_best_mask,
   output logic [FLOW_BITS-1:0]        rsp_cutflow_mask,
   output logic [COUNT_BITS-1:0]       rsp_candidate_count,
   output logic                        rsp_overflow,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [MASS_BITS-1:0]        csr_reference_mass
);

   ctrl_cmd_type cmd;

   bcps_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_last_candidate (req_last_candidate),
      .req_stall          (req_stall),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .cmd                (cmd)
   );

   bcps_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .csr_reference_mass   (csr_reference_mass),
      .req_first_pair_mass  (req_first_pair_mass),
      .req_second_pair_mass (req_second_pair_mass),
      .req_cut_bits         (req_cut_bits),
      .req_mixed_flavour    (req_mixed_flavour),
      .rsp_best_mask        (rsp_best_mask),
      .rsp_cutflow_mask     (rsp_cutflow_mask),
      .rsp_candidate_count  (rsp_candidate_count),
      .rsp_overflow         (rsp_overflow)
   );

endmodule

[src/bcps_ctrl.sv]
// ----------------------------------------------------------------------------
// bcps_ctrl
// Handshake controller: tracks the result register and issues commands to
// the datapath.
// ----------------------------------------------------------------------------
module bcps_ctrl
   import bcps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_last_candidate,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  logic         csr_valid,
   output logic         csr_ready,
   output ctrl_cmd_type cmd
);

   typedef enum logic {
      ST_EMPTY,
      ST_FULL
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // a held result only blocks input when it cannot leave this cycle
   assign req_stall  = (state_ff == ST_FULL) && rsp_stall;
   assign csr_ready  = (state_ff == ST_EMPTY);
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      cmd.accept    = req_valid && !req_stall;
      cmd.finish    = cmd.accept && req_last_candidate;
      cmd.cfg_write = csr_valid && csr_ready;

      state_in = state_ff;
      case (state_ff)
         ST_EMPTY: begin
            if (cmd.finish) state_in = ST_FULL;
         end
         ST_FULL: begin
            if (!rsp_stall && !cmd.finish) state_in = ST_EMPTY;
         end
         default: state_in = ST_EMPTY;
      endcase
      rsp_valid_in = (state_in == ST_FULL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_EMPTY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[src/bcps_datapath.sv]
// ----------------------------------------------------------------------------
// bcps_datapath
// Running lexicographic best search, cut-flow accumulation and the result
// register.
// ----------------------------------------------------------------------------
module bcps_datapath
   import bcps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   input  logic [MASS_BITS-1:0]  csr_reference_mass,
   input  logic [MASS_BITS-1:0]  req_first_pair_mass,
   input  logic signed [MASS_BITS-1:0] req_second_pair_mass,
   input  logic [CUT_BITS-1:0]   req_cut_bits,
   input  logic                  req_mixed_flavour,
   output logic [MASK_BITS-1:0]  rsp_best_mask,
   output logic [FLOW_BITS-1:0]  rsp_cutflow_mask,
   output logic [COUNT_BITS-1:0] rsp_candidate_count,
   output logic                  rsp_overflow
);

   logic [MASS_BITS-1:0]  ref_mass_ff;
   logic [MASS_BITS-1:0]  best_dist_ff,   best_dist_in;
   logic [MASS_BITS-1:0]  best_sec_ff,    best_sec_in;
   logic                  have_best_ff,   have_best_in;
   logic [MASK_BITS-1:0]  sel_mask_ff,    sel_mask_in;
   logic [ANY_BITS-1:0]   any_stage_ff,   any_stage_in;
   logic [HIGH_BITS-1:0]  best_stage_ff,  best_stage_in;
   logic [COUNT_BITS-1:0] slot_ff,        slot_in;
   logic                  dropped_ff,     dropped_in;

   logic [MASK_BITS-1:0]  best_mask_ff;
   logic [FLOW_BITS-1:0]  cutflow_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic                  overflow_ff;

   logic [MASS_BITS-1:0]  sec_raw;
   logic [MASS_BITS-1:0]  sec_abs;
   logic [MASS_BITS-1:0]  mass_dist;
   logic [CUT_BITS-1:0]   pm;
   logic [HIGH_BITS-1:0]  high_s;
   logic [MASK_BITS-1:0]  slot_bit;
   logic                  slots_full;
   logic                  qualifies;
   logic                  better;
   logic                  tied;

   always_comb begin
      sec_raw = req_second_pair_mass;
      // most negative value wraps to 2^(n-1), still fits unsigned
      sec_abs = sec_raw[MASS_BITS-1] ? (~sec_raw + MASS_BITS'(1)) : sec_raw;
      mass_dist = (ref_mass_ff >= req_first_pair_mass) ?
                  (ref_mass_ff - req_first_pair_mass) :
                  (req_first_pair_mass - ref_mass_ff);

      high_s = '0;
      if (&req_cut_bits[7:0]) high_s = high_s | (req_mixed_flavour ? 6'b000001 : 6'b000010);
      if (&req_cut_bits[8:0]) high_s = high_s | (req_mixed_flavour ? 6'b000100 : 6'b001000);
      if (&req_cut_bits[9:0]) high_s = high_s | (req_mixed_flavour ? 6'b010000 : 6'b100000);

      slots_full = (slot_ff >= COUNT_BITS'(MAX_CANDIDATES));
      qualifies  = &req_cut_bits[ANY_BITS-1:0];
      slot_bit   = MASK_BITS'(1) << slot_ff[SLOT_IDX_BITS-1:0];
      better     = !have_best_ff || (mass_dist < best_dist_ff) ||
                   ((mass_dist == best_dist_ff) && (sec_abs > best_sec_ff));
      tied       = (mass_dist == best_dist_ff) && (sec_abs == best_sec_ff);

      pm            = '0;
      best_dist_in  = best_dist_ff;
      best_sec_in   = best_sec_ff;
      have_best_in  = have_best_ff;
      sel_mask_in   = sel_mask_ff;
      any_stage_in  = any_stage_ff;
      best_stage_in = best_stage_ff;
      slot_in       = slot_ff;
      dropped_in    = dropped_ff;

      if (slots_full) begin
         dropped_in = 1'b1;
      end else begin
         for (int k = 0; k < ANY_BITS; k++) begin
            pm = CUT_BITS'((2 << k) - 1);
            if ((req_cut_bits & pm) == pm) any_stage_in[k] = 1'b1;
         end
         if (qualifies) begin
            if (better) begin
               have_best_in  = 1'b1;
               best_dist_in  = mass_dist;
               best_sec_in   = sec_abs;
               sel_mask_in   = slot_bit;
               best_stage_in = high_s;
            end else if (tied) begin
               sel_mask_in   = sel_mask_ff | slot_bit;
               best_stage_in = best_stage_ff | high_s;
            end
         end
         slot_in = slot_ff + COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_mass_ff <= REF_MASS_RESET;
      end else if (cmd.cfg_write) begin
         ref_mass_ff <= csr_reference_mass;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         best_dist_ff  <= '0;
         best_sec_ff   <= '0;
         have_best_ff  <= 1'b0;
         sel_mask_ff   <= '0;
         any_stage_ff  <= '0;
         best_stage_ff <= '0;
         slot_ff       <= '0;
         dropped_ff    <= 1'b0;
      end else if (cmd.accept) begin
         best_dist_ff  <= best_dist_in;
         best_sec_ff   <= best_sec_in;
         have_best_ff  <= have_best_in;
         sel_mask_ff   <= sel_mask_in;
         any_stage_ff  <= any_stage_in;
         best_stage_ff <= best_stage_in;
         slot_ff       <= slot_in;
         dropped_ff    <= dropped_in;
      end
   end

   // result register: loaded with the event totals including the last beat
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         best_mask_ff <= sel_mask_in;
         cutflow_ff   <= {best_stage_in, any_stage_in};
         count_ff     <= slot_in;
         overflow_ff  <= dropped_in;
      end
   end

   assign rsp_best_mask       = best_mask_ff;
   assign rsp_cutflow_mask    = cutflow_ff;
   assign rsp_candidate_count = count_ff;
   assign rsp_overflow        = overflow_ff;

endmodule

[tb/sv/best_candidate_pair_select_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// best_candidate_pair_select_unit_test
// Streams candidate events through the pair select unit and checks every
// result beat against a cycle-free model of the best-pair search, across
// several reference mass settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module best_candidate_pair_select_unit_test;
   import bcps_pkg::*;

   localparam int                   LONG_HOLD   = 400;
   localparam int                   QUIET_LIMIT = 3000;
   localparam int                   PHASE_ITEMS = 100;
   localparam logic [MASS_BITS-1:0] MASS_MAX    = {MASS_BITS{1'b1}};
   localparam logic [MASS_BITS-1:0] MASS_MIN_NEG = {1'b1, {(MASS_BITS-1){1'b0}}};
   localparam logic [MASS_BITS-1:0] MASS_MAX_POS = {1'b0, {(MASS_BITS-1){1'b1}}};
   localparam logic [CUT_BITS-1:0]  CUTS_ALL    = {CUT_BITS{1'b1}};
   localparam logic [CUT_BITS-1:0]  CUTS_QUAL   = 10'h07F;

   typedef struct {
      logic [MASS_BITS-1:0] first_mass;
      logic [MASS_BITS-1:0] second_mass;
      logic [CUT_BITS-1:0]  cuts;
      logic                 mixed;
      logic                 is_last;
   } candidate_type;

   typedef struct {
      logic [MASK_BITS-1:0]  best_mask;
      logic [FLOW_BITS-1:0]  flow_mask;
      logic [COUNT_BITS-1:0] count;
      logic                  overflow;
   } summary_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [MASS_BITS-1:0]        req_first_pair_mass = '0;
   logic signed [MASS_BITS-1:0] req_second_pair_mass = '0;
   logic [CUT_BITS-1:0]         req_cut_bits = '0;
   logic                        req_mixed_flavour = 1'b0;
   logic                        req_last_candidate = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [MASK_BITS-1:0]        rsp_best_mask;
   logic [FLOW_BITS-1:0]        rsp_cutflow_mask;
   logic [COUNT_BITS-1:0]       rsp_candidate_count;
   logic                        rsp_overflow;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [MASS_BITS-1:0]        csr_reference_mass = '0;

   // model state of the running event
   logic [MASS_BITS-1:0] ref_mass_model = REF_MASS_RESET;
   logic [MASS_BITS-1:0] best_dist;
   logic [MASS_BITS-1:0] best_second;
   logic                 have_best;
   logic [MASK_BITS-1:0] marked_slots;
   logic [ANY_BITS-1:0]  any_stages;
   logic [HIGH_BITS-1:0] best_stages;
   int                   slot_count;
   logic                 dropped;

   candidate_type candidate_queue[$];
   summary_type   expected_summaries[$];
   candidate_type beat_on_bus;
   summary_type   seen_summary;
   summary_type   due_summary;
   int         items_queued = 0;
   int         items_taken = 0;
   int         gap_left = 0;
   int         stall_left = 0;
   int         holds_asked = 0;
   int         holds_done = 0;
   int         quiet_cycles = 0;
   int         mismatch_count = 0;
   bit         calm_mode = 1'b0;

   best_candidate_pair_select_unit DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_first_pair_mass (req_first_pair_mass),
      .req_second_pair_mass(req_second_pair_mass),
      .req_cut_bits        (req_cut_bits),
      .req_mixed_flavour   (req_mixed_flavour),
      .req_last_candidate  (req_last_candidate),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_best_mask       (rsp_best_mask),
      .rsp_cutflow_mask    (rsp_cutflow_mask),
      .rsp_candidate_count (rsp_candidate_count),
      .rsp_overflow        (rsp_overflow),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_reference_mass  (csr_reference_mass)
   );

   always #10 clock = ~clock;

   function automatic void clear_event_model();
      best_dist    = '0;
      best_second  = '0;
      have_best    = 1'b0;
      marked_slots = '0;
      any_stages   = '0;
      best_stages  = '0;
      slot_count   = 0;
      dropped      = 1'b0;
   endfunction

   // streaming lexicographic search: nearest first mass, then largest |second|
   function automatic void track_candidate(candidate_type c);
      logic [MASS_BITS-1:0] sec_abs;
      logic [MASS_BITS-1:0] mass_dist;
      logic [CUT_BITS-1:0]  prefix;
      logic [HIGH_BITS-1:0] hi;
      summary_type          s;
      if (slot_count >= MAX_CANDIDATES) begin
         dropped = 1'b1;
      end else begin
         for (int k = 0; k < ANY_BITS; k++) begin
            prefix = (CUT_BITS'(2) << k) - CUT_BITS'(1);
            if ((c.cuts & prefix) == prefix)
               any_stages[k] = 1'b1;
         end
         if ((c.cuts & CUTS_QUAL) == CUTS_QUAL) begin
            sec_abs = c.second_mass[MASS_BITS-1] ? (~c.second_mass + 1'b1) : c.second_mass;
            mass_dist = (ref_mass_model >= c.first_mass) ? ref_mass_model - c.first_mass
                                                         : c.first_mass - ref_mass_model;
            hi = '0;
            if (c.cuts[7:0] == 8'hFF) hi |= c.mixed ? 6'b000001 : 6'b000010;
            if (c.cuts[8:0] == 9'h1FF) hi |= c.mixed ? 6'b000100 : 6'b001000;
            if (c.cuts == CUTS_ALL) hi |= c.mixed ? 6'b010000 : 6'b100000;
            if (!have_best || mass_dist < best_dist ||
                (mass_dist == best_dist && sec_abs > best_second)) begin
               have_best    = 1'b1;
               best_dist    = mass_dist;
               best_second  = sec_abs;
               marked_slots = MASK_BITS'(1) << slot_count;
               best_stages  = hi;
            end else if (mass_dist == best_dist && sec_abs == best_second) begin
               marked_slots |= MASK_BITS'(1) << slot_count;
               best_stages  |= hi;
            end
         end
         slot_count++;
      end
      if (c.is_last) begin
         s.best_mask = marked_slots;
         s.flow_mask = {best_stages, any_stages};
         s.count     = COUNT_BITS'(slot_count);
         s.overflow  = dropped;
         expected_summaries.push_back(s);
         clear_event_model();
      end
   endfunction

   function automatic int pick_idle();
      int r;
      if (calm_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void report_mismatch(string what, summary_type e, summary_type g);
      if (mismatch_count < 10)
         $display("mismatch (%s): expected mask=%h flow=%h count=%0d ovf=%0b, ",
                  what, e.best_mask, e.flow_mask, e.count, e.overflow,
                  "got mask=%h flow=%h count=%0d ovf=%0b",
                  g.best_mask, g.flow_mask, g.count, g.overflow);
      mismatch_count++;
   endfunction

   task automatic add_candidate(logic [MASS_BITS-1:0] m1, logic [MASS_BITS-1:0] m2,
                                logic [CUT_BITS-1:0] cuts, logic mixed, logic is_last);
      candidate_type c;
      c.first_mass  = m1;
      c.second_mass = m2;
      c.cuts        = cuts;
      c.mixed       = mixed;
      c.is_last     = is_last;
      candidate_queue.push_back(c);
      items_queued++;
   endtask

   // mostly qualifying candidates clustered near the reference so ties happen
   task automatic add_random_event(int n);
      logic [MASS_BITS-1:0] m1, m2;
      logic [CUT_BITS-1:0]  cuts;
      int                   r, off;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            case ($urandom_range(0, 4))
               0: cuts = CUTS_QUAL;
               1: cuts = 10'h0FF;
               2: cuts = 10'h1FF;
               3: cuts = CUTS_ALL;
               default: cuts = {3'($urandom), 7'h7F};
            endcase
         end else if (r < 90) begin
            cuts = CUT_BITS'((11'd1 << $urandom_range(0, 10)) - 11'd1);
         end else begin
            cuts = CUT_BITS'($urandom);
         end
         r = $urandom_range(0, 99);
         off = $urandom_range(0, 3);
         if (r < 70) m1 = $urandom_range(0, 1) ? ref_mass_model + MASS_BITS'(off)
                                               : ref_mass_model - MASS_BITS'(off);
         else if (r < 75) m1 = '0;
         else if (r < 80) m1 = MASS_MAX;
         else m1 = MASS_BITS'($urandom);
         r = $urandom_range(0, 99);
         if (r < 70) begin
            case ($urandom_range(0, 3))
               0: m2 = MASS_BITS'(0);
               1: m2 = MASS_BITS'(1);
               2: m2 = MASS_BITS'(5);
               default: m2 = MASS_BITS'(100);
            endcase
            if ($urandom_range(0, 1)) m2 = ~m2 + 1'b1;
         end else if (r < 75) begin
            m2 = MASS_MIN_NEG;
         end else if (r < 80) begin
            m2 = MASS_MAX_POS;
         end else begin
            m2 = MASS_BITS'($urandom);
         end
         add_candidate(m1, m2, cuts, 1'($urandom), i == n - 1);
      end
   endtask

   function automatic int pick_event_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 8);
      if (r < 96) return $urandom_range(9, 30);
      return $urandom_range(60, 70);
   endfunction

   task automatic run_random_phase();
      int start;
      start = items_queued;
      while (items_queued - start < PHASE_ITEMS)
         add_random_event(pick_event_length());
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (items_taken != items_queued || expected_summaries.size() != 0);
      // the block may still be closing the last beat
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reference(logic [MASS_BITS-1:0] value);
      wait_idle();
      csr_valid          <= 1'b1;
      csr_reference_mass <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid      <= 1'b0;
      ref_mass_model = value;
      @(negedge clock);
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            track_candidate(beat_on_bus);
            items_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (candidate_queue.size() != 0) begin
               beat_on_bus = candidate_queue.pop_front();
               req_first_pair_mass  <= beat_on_bus.first_mass;
               req_second_pair_mass <= beat_on_bus.second_mass;
               req_cut_bits         <= beat_on_bus.cuts;
               req_mixed_flavour    <= beat_on_bus.mixed;
               req_last_candidate   <= beat_on_bus.is_last;
               req_valid            <= 1'b1;
               gap_left = pick_idle();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure, with an occasional long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (holds_asked != holds_done) begin
         holds_done++;
         stall_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = pick_idle();
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_summary.best_mask = rsp_best_mask;
         seen_summary.flow_mask = rsp_cutflow_mask;
         seen_summary.count     = rsp_candidate_count;
         seen_summary.overflow  = rsp_overflow;
         if (expected_summaries.size() == 0) begin
            due_summary = '{default: '0};
            report_mismatch("unexpected beat", due_summary, seen_summary);
         end else begin
            due_summary = expected_summaries.pop_front();
            if (seen_summary.best_mask !== due_summary.best_mask ||
                seen_summary.flow_mask !== due_summary.flow_mask ||
                seen_summary.count !== due_summary.count ||
                seen_summary.overflow !== due_summary.overflow)
               report_mismatch("field", due_summary, seen_summary);
         end
      end
   end

   always @(posedge clock) begin
      if (reset ||
          (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
            $display("best_candidate_pair_select_unit_test: done, errors");
            $finish;
         end
      end
   end

   initial begin
      clear_event_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed events at the reset reference
      // exact match, tie on both keys across flavours, smaller |second| loses
      add_candidate(REF_MASS_RESET, MASS_MIN_NEG, CUTS_ALL, 1'b1, 1'b0);
      add_candidate(REF_MASS_RESET, MASS_MAX_POS, CUTS_ALL, 1'b0, 1'b0);
      add_candidate(REF_MASS_RESET, MASS_MIN_NEG, CUTS_ALL, 1'b0, 1'b0);
      add_candidate(REF_MASS_RESET + 1'b1, MASS_MIN_NEG, CUTS_ALL, 1'b1, 1'b0);
      add_candidate(REF_MASS_RESET - MASS_BITS'(5), '0, CUTS_QUAL, 1'b0, 1'b1);
      // nothing qualifies
      add_candidate('0, '0, 10'h000, 1'b0, 1'b0);
      add_candidate(MASS_MAX, MASS_MAX_POS, 10'h03F, 1'b1, 1'b0);
      add_candidate(REF_MASS_RESET, MASS_BITS'(5), 10'h3BF, 1'b1, 1'b1);
      // zero second mass ties from both sides of the reference
      add_candidate('0, '0, CUTS_QUAL, 1'b1, 1'b0);
      add_candidate(MASS_MAX, '0, 10'h0FF, 1'b0, 1'b0);
      add_candidate(REF_MASS_RESET << 1, '0, 10'h1FF, 1'b1, 1'b0);
      add_candidate(REF_MASS_RESET << 1, '0, CUTS_ALL, 1'b0, 1'b0);
      add_candidate('0, '0, CUTS_QUAL, 1'b0, 1'b1);
      // single far candidate is still eligible
      add_candidate(MASS_MAX, MASS_MAX, CUTS_ALL, 1'b0, 1'b1);
      add_candidate(REF_MASS_RESET, MASS_BITS'(1), 10'h1FF, 1'b1, 1'b0);
      add_candidate(REF_MASS_RESET, MASS_MAX, 10'h0FF, 1'b0, 1'b1);

      write_reference(MASS_BITS'($urandom));
      run_random_phase();

      write_reference('0);
      run_random_phase();

      // back to back, with capacity overflow forced
      write_reference(MASS_MAX);
      calm_mode = 1'b1;
      add_random_event(MAX_CANDIDATES);
      add_random_event(MAX_CANDIDATES + 1);
      add_random_event(MAX_CANDIDATES + 6);
      run_random_phase();
      wait_idle();
      calm_mode = 1'b0;

      // long receiver hold-off while candidates keep coming
      write_reference(MASS_BITS'($urandom));
      run_random_phase();
      holds_asked++;

      write_reference(REF_MASS_RESET);
      run_random_phase();

      write_reference(MASS_BITS'($urandom));
      run_random_phase();

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("best_candidate_pair_select_unit_test: done, clean");
      else
         $display("best_candidate_pair_select_unit_test: done, errors");
      $finish;
   end

endmodule

[filelist.f]
src/bcps_pkg.sv
src/bcps_ctrl.sv
src/bcps_datapath.sv
src/best_candidate_pair_select_unit.sv
tb/sv/best_candidate_pair_select_unit_test.sv
